// ----- rtl/gcd_pkg.sv -----
`default_nettype none

package gcd_pkg;

  localparam int FRAC_BITS = 20;

  // 360 degrees = 45 * 2^3 * 2^FRAC_BITS
  localparam int TURN_DIV = 45;
  localparam int LAT_SH   = 32 - FRAC_BITS - 3;
  localparam int HALF_SH  = 31 - FRAC_BITS - 3;
  localparam int TURN_RND = 180 >> 3;
  localparam logic [30:0] RECIP45 = 31'd95443718;

  localparam logic [30:0] Q_ONE  = 31'h4000_0000;
  localparam logic [29:0] Q_HALF = 30'h2000_0000;

  localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;
  localparam logic [36:0] TEN_PI_Q32  = 37'd134930377045;

  localparam logic [22:0] RADIUS_RESET = 23'd6378137;
  localparam logic [27:0] DIST_MAX     = 28'hFFF_FFFF;

  localparam int SINE_ITERS = 7;
  localparam int QS_LAT     = 3 * SINE_ITERS + 4;
  localparam int ASIN_BITS  = 29;
  localparam int LATENCY    = 12 + QS_LAT + ASIN_BITS * (QS_LAT + 1);

  typedef struct packed {
    logic [28:0] p;
    logic [29:0] target;
    logic        lower;
  } asin_state_t;

  // floor(x / d) for x < 2^25, rc = ceil(2^32 / d), odd d < 128
  function automatic logic [23:0] mul_recip(input logic [24:0] x, input logic [30:0] rc);
    logic [55:0] prod;
    prod = 56'(x) * 56'(rc);
    return prod[55:32];
  endfunction

  // Q30 product, both operands at most 1.0
  function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
    logic [61:0] prod;
    prod = 62'(a) * 62'(b);
    return prod[60:30];
  endfunction

  // series divisors 2k(2k+1), k = 7 down to 1, split as 2^shift * odd
  function automatic int sine_shift(input int i);
    case (i)
      0: return 1;
      1: return 2;
      2: return 1;
      3: return 3;
      4: return 1;
      5: return 2;
      6: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [6:0] sine_odd(input int i);
    case (i)
      0: return 7'd105;
      1: return 7'd39;
      2: return 7'd55;
      3: return 7'd9;
      4: return 7'd21;
      5: return 7'd5;
      6: return 7'd3;
      default: return 7'd1;
    endcase
  endfunction

  function automatic logic [30:0] sine_recip(input int i);
    case (i)
      0: return 31'd40904451;
      1: return 31'd110127367;
      2: return 31'd78090315;
      3: return 31'd477218589;
      4: return 31'd204522253;
      5: return 31'd858993460;
      6: return 31'd1431655766;
      default: return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- rtl/gcd_qsine.sv -----
`default_nettype none

module gcd_qsine (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] r,
  output logic [30:0] s
);

  localparam int N = gcd_pkg::SINE_ITERS;

  logic [47:0] p_hi;
  logic [46:0] p_lo;
  logic [63:0] x_sum;
  logic [30:0] x0;
  logic [30:0] x1;
  logic [61:0] x0_sq;
  logic [31:0] x2_1;

  logic [30:0] xa  [N];
  logic [31:0] x2a [N];
  logic [31:0] ma  [N];
  logic [30:0] xb  [N];
  logic [31:0] x2b [N];
  logic [15:0] qb  [N];
  logic [22:0] zb  [N];
  logic [30:0] xc  [N];
  logic [31:0] x2c [N];
  logic [30:0] tc  [N];

  logic [30:0] x_in   [N];
  logic [31:0] x2_in  [N];
  logic [30:0] t_in   [N];
  logic [62:0] m_prod [N];
  logic [31:0] y      [N];
  logic [23:0] qh     [N];
  logic [22:0] qo     [N];
  logic [6:0]  rh     [N];
  logic [23:0] ql     [N];
  logic [31:0] q_sum  [N];
  logic [61:0] f_prod;

  always_comb begin
    x_sum = {p_hi, 16'b0} + 64'(p_lo);
    x0_sq = 62'(x0) * 62'(x0);
    x_in[0]  = x1;
    x2_in[0] = x2_1;
    t_in[0]  = gcd_pkg::Q_ONE;
    for (int i = 1; i < N; i++) begin
      x_in[i]  = xc[i-1];
      x2_in[i] = x2c[i-1];
      t_in[i]  = tc[i-1];
    end
    for (int i = 0; i < N; i++) begin
      m_prod[i] = 63'(x2_in[i]) * 63'(t_in[i]);
      y[i]      = ma[i] >> gcd_pkg::sine_shift(i);
      qh[i]     = gcd_pkg::mul_recip(25'(y[i][31:16]), gcd_pkg::sine_recip(i));
      qo[i]     = 23'(qh[i][15:0]) * 23'(gcd_pkg::sine_odd(i));
      rh[i]     = 7'(23'(y[i][31:16]) - qo[i]);
      ql[i]     = gcd_pkg::mul_recip(25'(zb[i]), gcd_pkg::sine_recip(i));
      q_sum[i]  = {qb[i], 16'b0} + 32'(ql[i]);
    end
    f_prod = 62'(xc[N-1]) * 62'(tc[N-1]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_hi <= 48'(r) * 48'(gcd_pkg::HALF_PI_Q32[32:16]);
      p_lo <= 47'(r) * 47'(gcd_pkg::HALF_PI_Q32[15:0]);
      x0   <= x_sum[62:32];
      x1   <= x0;
      x2_1 <= x0_sq[61:30];
      for (int i = 0; i < N; i++) begin
        xa[i]  <= x_in[i];
        x2a[i] <= x2_in[i];
        ma[i]  <= m_prod[i][61:30];
        xb[i]  <= xa[i];
        x2b[i] <= x2a[i];
        qb[i]  <= qh[i][15:0];
        zb[i]  <= {rh[i], y[i][15:0]};
        xc[i]  <= xb[i];
        x2c[i] <= x2b[i];
        tc[i]  <= gcd_pkg::Q_ONE - q_sum[i][30:0];
      end
      s <= (f_prod[61:30] > 32'(gcd_pkg::Q_ONE)) ? gcd_pkg::Q_ONE : f_prod[60:30];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/gcd_asin_step.sv -----
`default_nettype none

module gcd_asin_step (
  input  logic                 clk,
  input  logic                 en,
  input  logic [28:0]          bit_mask,
  input  gcd_pkg::asin_state_t st_in,
  output gcd_pkg::asin_state_t st_out
);

  localparam int L = gcd_pkg::QS_LAT;

  logic [28:0]          cand;
  logic [30:0]          s;
  logic [30:0]          s_sq;
  gcd_pkg::asin_state_t st_d [L];

  assign cand = st_in.p | bit_mask;
  assign s_sq = gcd_pkg::mul_q30(s, s);

  gcd_qsine u_sine (
    .clk (clk),
    .en  (en),
    .r   ({2'b0, cand}),
    .s   (s)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      st_d[0] <= st_in;
      for (int i = 1; i < L; i++) begin
        st_d[i] <= st_d[i-1];
      end
      st_out.target <= st_d[L-1].target;
      st_out.lower  <= st_d[L-1].lower;
      st_out.p      <= (s_sq <= 31'(st_d[L-1].target)) ? st_d[L-1].p | bit_mask
                                                       : st_d[L-1].p;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/great_circle_distance.sv -----
// Pipelined around the 25-stage sine unit.
// Throughput: one position pair per cycle unless the output stalls; the arcsine is 29
// bisection steps, each a full sine pipeline, so every stage holds its own item.
// Output stall freezes the whole pipeline; bubbles still fill while the output is empty.
// Reset (rst, synchronous) clears all valid bits and loads the default radius.
`default_nettype none

module great_circle_distance (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [27:0] lat_a,
  input  logic signed [28:0] lon_a,
  input  logic signed [27:0] lat_b,
  input  logic signed [28:0] lon_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [27:0]        distance,
  input  logic               cfg_we,
  input  logic [22:0]        cfg_wdata
);

  localparam int L      = gcd_pkg::QS_LAT;
  localparam int NB     = gcd_pkg::ASIN_BITS;
  localparam int LAT    = gcd_pkg::LATENCY;
  localparam int T7_IDX = 6 + gcd_pkg::QS_LAT;

  logic           en;
  logic [LAT-1:0] vld;
  logic [22:0]    radius;

  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      radius <= gcd_pkg::RADIUS_RESET;
    end else begin
      if (en) vld <= {vld[LAT-2:0], in_valid};
      if (cfg_we) radius <= cfg_wdata;
    end
  end

  // angle conversion: 0 half dlat, 1 half dlon, 2 lat_a, 3 lat_b
  logic signed [28:0] dlat;
  logic signed [29:0] dlon;
  logic [28:0]        mag_dlat;
  logic [29:0]        mag_dlon;
  logic [27:0]        mag_la;
  logic [27:0]        mag_lb;
  logic [37:0]        m_next [4];
  logic [3:0]         n_next;

  logic [37:0] m1  [4];
  logic [3:0]  n1;
  logic [13:0] qh2 [4];
  logic [24:0] z2  [4];
  logic [3:0]  n2;
  logic [31:0] ang3 [4];
  logic [30:0] r4  [4];
  logic [3:0]  sg4;

  logic [18:0] hi2 [4];
  logic [23:0] qh_f [4];
  logic [5:0]  rh2 [4];
  logic [23:0] ql3 [4];
  logic [32:0] q3  [4];
  logic [31:0] turn3 [4];
  logic [31:0] ang_next [4];

  always_comb begin
    dlat     = {lat_a[27], lat_a} - {lat_b[27], lat_b};
    dlon     = {lon_a[28], lon_a} - {lon_b[28], lon_b};
    mag_dlat = dlat[28] ? 29'(-dlat) : 29'(dlat);
    mag_dlon = dlon[29] ? 30'(-dlon) : 30'(dlon);
    mag_la   = lat_a[27] ? 28'(-lat_a) : 28'(lat_a);
    mag_lb   = lat_b[27] ? 28'(-lat_b) : 28'(lat_b);
    m_next[0] = (38'(mag_dlat) << gcd_pkg::HALF_SH) + 38'(gcd_pkg::TURN_RND);
    m_next[1] = (38'(mag_dlon) << gcd_pkg::HALF_SH) + 38'(gcd_pkg::TURN_RND);
    m_next[2] = (38'(mag_la) << gcd_pkg::LAT_SH) + 38'(gcd_pkg::TURN_RND);
    m_next[3] = (38'(mag_lb) << gcd_pkg::LAT_SH) + 38'(gcd_pkg::TURN_RND);
    n_next    = {lat_b[27], lat_a[27], dlon[29], dlat[28]};
    for (int i = 0; i < 4; i++) begin
      hi2[i]   = m1[i][37:19];
      qh_f[i]  = gcd_pkg::mul_recip(25'(hi2[i]), gcd_pkg::RECIP45);
      rh2[i]   = 6'(hi2[i] - 19'(qh_f[i][13:0]) * 19'(gcd_pkg::TURN_DIV));
      ql3[i]   = gcd_pkg::mul_recip(z2[i], gcd_pkg::RECIP45);
      q3[i]    = {qh2[i], 19'b0} + 33'(ql3[i]);
      turn3[i] = n2[i] ? 32'(-q3[i][31:0]) : q3[i][31:0];
      ang_next[i] = (i >= 2) ? turn3[i] + 32'(gcd_pkg::Q_ONE) : turn3[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1 <= n_next;
      n2 <= n1;
      for (int i = 0; i < 4; i++) begin
        m1[i]   <= m_next[i];
        qh2[i]  <= qh_f[i][13:0];
        z2[i]   <= {rh2[i], m1[i][18:0]};
        ang3[i] <= ang_next[i];
        r4[i]   <= ang3[i][30] ? gcd_pkg::Q_ONE - 31'(ang3[i][29:0]) : 31'(ang3[i][29:0]);
        sg4[i]  <= ang3[i][31];
      end
    end
  end

  // sines and cosines
  logic [30:0] s_q [4];
  logic [3:0]  sg_d [L];

  for (genvar g = 0; g < 4; g++) begin : g_sine
    gcd_qsine u_sine (
      .clk (clk),
      .en  (en),
      .r   (r4[g]),
      .s   (s_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg_d[0] <= sg4;
      for (int i = 1; i < L; i++) begin
        sg_d[i] <= sg_d[i-1];
      end
    end
  end

  // haversine term
  logic [30:0] a5, cc5, sl5, a6, b6;
  logic        neg5, neg6;
  logic [31:0] h_raw;
  logic [30:0] h_cl;
  logic [29:0] tgt7;
  logic        lower7;

  always_comb begin
    if (neg6) begin
      h_raw = (b6 > a6) ? '0 : 32'(a6 - b6);
    end else begin
      h_raw = 32'(a6) + 32'(b6);
    end
    h_cl = (h_raw > 32'(gcd_pkg::Q_ONE)) ? gcd_pkg::Q_ONE : h_raw[30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a5     <= gcd_pkg::mul_q30(s_q[0], s_q[0]);
      cc5    <= gcd_pkg::mul_q30(s_q[2], s_q[3]);
      sl5    <= gcd_pkg::mul_q30(s_q[1], s_q[1]);
      neg5   <= sg_d[L-1][2] ^ sg_d[L-1][3];
      a6     <= a5;
      b6     <= gcd_pkg::mul_q30(cc5, sl5);
      neg6   <= neg5;
      lower7 <= h_cl <= 31'(gcd_pkg::Q_HALF);
      tgt7   <= (h_cl <= 31'(gcd_pkg::Q_HALF)) ? h_cl[29:0] : 30'(gcd_pkg::Q_ONE - h_cl);
    end
  end

  // arcsine by bisection, one sine pipeline per bit
  gcd_pkg::asin_state_t ast [NB+1];

  assign ast[0].p      = '0;
  assign ast[0].target = tgt7;
  assign ast[0].lower  = lower7;

  for (genvar j = 0; j < NB; j++) begin : g_asin
    gcd_asin_step u_step (
      .clk      (clk),
      .en       (en),
      .bit_mask (29'(1) << (NB - 1 - j)),
      .st_in    (ast[j]),
      .st_out   (ast[j+1])
    );
  end

  // scale by radius, round to 0.1 m
  logic [30:0] t8;
  logic [53:0] tr;
  logic [44:0] pp_hh;
  logic [45:0] pp_hl;
  logic [44:0] pp_lh;
  logic [45:0] pp_ll;
  logic [90:0] sa;
  logic [90:0] sb;
  logic [90:0] sum;

  assign sum = sa + sb;

  always_ff @(posedge clk) begin
    if (en) begin
      t8 <= ast[NB].lower ? 31'(ast[NB].p) : gcd_pkg::Q_ONE - 31'(ast[NB].p);
      tr <= 54'(t8) * 54'(radius);
      pp_hh <= 45'(tr[53:27]) * 45'(gcd_pkg::TEN_PI_Q32[36:19]);
      pp_hl <= 46'(tr[53:27]) * 46'(gcd_pkg::TEN_PI_Q32[18:0]);
      pp_lh <= 45'(tr[26:0]) * 45'(gcd_pkg::TEN_PI_Q32[36:19]);
      pp_ll <= 46'(tr[26:0]) * 46'(gcd_pkg::TEN_PI_Q32[18:0]);
      sa <= (91'(pp_hh) << 46) + (91'(pp_hl) << 27);
      sb <= (91'(pp_lh) << 19) + 91'(pp_ll) + (91'(1) << 61);
      distance <= sum[90] ? gcd_pkg::DIST_MAX : sum[89:62];
    end
  end

`ifndef ASSERT_OFF
  a_freeze: assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("pipeline moved while output stalled");
  a_target: assert property (@(posedge clk) disable iff (rst)
    vld[T7_IDX] |-> tgt7 <= gcd_pkg::Q_HALF)
    else $error("arcsine target above one half");
  a_refill: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall |=> !out_valid || $past(vld[LAT-2]))
    else $error("output beat without a preceding stage beat");
`endif

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
`default_nettype none

module testbench;

  localparam int LIM_CYCLES = 3000000;
  localparam longint LAT_MAX = 94371840;
  localparam longint LON_MAX = 188743680;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [27:0] lat_a = '0;
  logic signed [28:0] lon_a = '0;
  logic signed [27:0] lat_b = '0;
  logic signed [28:0] lon_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [27:0] distance;
  logic cfg_we = 1'b0;
  logic [22:0] cfg_wdata = '0;

  great_circle_distance dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .lat_a(lat_a), .lon_a(lon_a), .lat_b(lat_b), .lon_b(lon_b),
    .out_valid(out_valid), .out_stall(out_stall), .distance(distance),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  logic [22:0] radius_m = gcd_pkg::RADIUS_RESET;
  logic [27:0] dist_q[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIM_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= idle_on && ($urandom_range(99) < 15);
  end

  task automatic report(input string msg);
    errors++;
    $display("ERROR t=%0t %s", $realtime, msg);
  endtask

  function automatic logic [31:0] to_turn(input longint v, input int extra);
    longint unsigned den, mag, q;
    logic [31:0] a;
    den = 64'd360 << gcd_pkg::FRAC_BITS;
    mag = v < 0 ? -v : v;
    q = ((mag << extra) + den / 2) / den;
    a = q[31:0];
    return v < 0 ? -a : a;
  endfunction

  function automatic longint unsigned qsine(input longint unsigned r);
    longint unsigned x, x2, t, s;
    x = (r * 64'd6746518852) >> 32;
    x2 = (x * x) >> 30;
    t = 64'd1 << 30;
    for (int k = 7; k >= 1; k--)
      t = (64'd1 << 30) - ((x2 * t) >> 30) / ((2 * k) * (2 * k + 1));
    s = (x * t) >> 30;
    return s > (64'd1 << 30) ? (64'd1 << 30) : s;
  endfunction

  // magnitude and sign of sine of a binary angle
  function automatic longint unsigned tsine(input logic [31:0] a, output bit neg);
    longint unsigned r;
    r = a[29:0];
    neg = a[31];
    return a[30] ? qsine((64'd1 << 30) - r) : qsine(r);
  endfunction

  function automatic longint unsigned sq30(input longint unsigned m);
    return (m * m) >> 30;
  endfunction

  function automatic longint unsigned half_asin(input longint unsigned tgt);
    longint unsigned p, c;
    p = 0;
    for (int b = 28; b >= 0; b--) begin
      c = p | (64'd1 << b);
      if (sq30(qsine(c)) <= tgt) p = c;
    end
    return p;
  endfunction

  function automatic logic [27:0] haversine_dist(input longint la, lo_a, lb, lo_b);
    longint unsigned sl, so, ca, cb, at, bt, h, t, cc;
    bit n1, n2, n3, n4;
    logic [127:0] prod;
    sl = tsine(to_turn(la - lb, 31), n1);
    so = tsine(to_turn(lo_a - lo_b, 31), n2);
    ca = tsine(to_turn(la, 32) + 32'h4000_0000, n3);
    cb = tsine(to_turn(lb, 32) + 32'h4000_0000, n4);
    at = sq30(sl);
    cc = (ca * cb) >> 30;
    bt = (cc * sq30(so)) >> 30;
    if (n3 != n4) h = bt > at ? 0 : at - bt;
    else h = at + bt;
    if (h > (64'd1 << 30)) h = 64'd1 << 30;
    if (h <= (64'd1 << 29)) t = half_asin(h);
    else t = (64'd1 << 30) - half_asin((64'd1 << 30) - h);
    prod = 128'(t * radius_m) * 128'(64'd134930377045) + (128'd1 << 61);
    prod = prod >> 62;
    return prod > 128'(gcd_pkg::DIST_MAX) ? gcd_pkg::DIST_MAX : prod[27:0];
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (dist_q.size() == 0) report($sformatf("unexpected distance %0d", distance));
      else begin
        logic [27:0] e;
        e = dist_q.pop_front();
        if (distance !== e) report($sformatf("distance %0d, expected %0d", distance, e));
      end
    end
  end

  task automatic send(input longint la, lo_a, lb, lo_b);
    logic signed [27:0] la_t, lb_t;
    logic signed [28:0] lo_a_t, lo_b_t;
    la_t = 28'(la);
    lo_a_t = 29'(lo_a);
    lb_t = 28'(lb);
    lo_b_t = 29'(lo_b);
    while (idle_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    lat_a <= la_t; lon_a <= lo_a_t; lat_b <= lb_t; lon_b <= lo_b_t;
    dist_q.push_back(haversine_dist(la_t, lo_a_t, lb_t, lo_b_t));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (dist_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_radius(input logic [22:0] r);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    radius_m = r;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic longint rnd(input longint m);
    return longint'($urandom_range(2 * m)) - m;
  endfunction

  task automatic test_directed();
    send(0, 0, 0, 0);
    send(LAT_MAX, 0, -LAT_MAX, 0);
    send(0, LON_MAX, 0, -LON_MAX);
    send(0, 0, 0, LON_MAX);
    send(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send(-LAT_MAX, -LON_MAX, -LAT_MAX, LON_MAX);
    send(0, 0, 0, 1);
    send(1, 0, 0, 0);
    send(-1, -1, 1, 1);
    send(LAT_MAX / 2, LON_MAX / 3, -LAT_MAX / 4, LON_MAX / 5);
    send(LAT_MAX - 1, 7, -LAT_MAX + 1, 3);
    // latitudes beyond ninety degrees
    send(-28'sh800_0000, 0, 28'sh7FF_FFFF, 0);
    send(28'sh7FF_FFFF, -29'sh1000_0000, 28'sh7FF_FFFF, 29'sh0FFF_FFFF);
    send(28'sh7FF_FFFF, 29'sh0FFF_FFFF, -28'sh800_0000, -29'sh1000_0000);
    send(120 <<< 20, 10 <<< 20, 100 <<< 20, -150 <<< 20);
  endtask

  task automatic test_radius_extremes();
    set_radius(23'h7F_FFFF);
    send(LAT_MAX, 0, -LAT_MAX, 0);
    send(0, 0, 0, LON_MAX);
    send(0, 0, 1000, 1000);
    set_radius(23'(1));
    send(LAT_MAX, 0, -LAT_MAX, 0);
    send(0, 0, 0, 1);
    set_radius(23'(0));
    send(LAT_MAX, 0, -LAT_MAX, 0);
    set_radius(gcd_pkg::RADIUS_RESET);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: send($signed(28'($urandom)), $signed(29'($urandom)),
                $signed(28'($urandom)), $signed(29'($urandom)));
        1: begin
          longint la, lo;
          la = rnd(LAT_MAX); lo = rnd(LON_MAX);
          send(la, lo, la + rnd(5000), lo + rnd(5000));
        end
        default: send(rnd(LAT_MAX), rnd(LON_MAX), rnd(LAT_MAX), rnd(LON_MAX));
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_radius_extremes();
    test_random(500);
    set_radius(23'($urandom_range(1, 8388607)));
    idle_on = 1'b0;
    test_random(400);
    idle_on = 1'b1;
    set_radius(23'(6371000));
    test_random(400);
    drain();
    test_random(480);
    drain();
    repeat (gcd_pkg::LATENCY + 20) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/gcd_pkg.sv
rtl/gcd_qsine.sv
rtl/gcd_asin_step.sv
rtl/great_circle_distance.sv
verif/testbench.sv
